// ===== rtl/fdf_pkg.sv =====
// Shared constants and types for the fixed decimal formatter.
// Used by fdf_bcd, fdf_charbuf and fixed_decimal_formatter_unit; no dependencies.
package fdf_pkg;

	localparam int MAX_PREC_DEF       = 44;
	localparam int MAX_INT_DIGITS_DEF = 19;

	localparam int MAG_W  = 63;
	localparam int NDIG_W = 5;
	localparam int FRAC_W = 64;
	localparam int PREC_W = 6;
	localparam int CHAR_W = 8;
	localparam int LEN_W  = 7;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
	localparam logic [3:0]        ROUND_DIGIT = 4'd5;
	localparam logic [3:0]        BASE        = 4'd10;

	typedef struct packed {
		logic load;
		logic conv;
		logic pop;
	} bcd_ctrl_t;

endpackage

// ===== rtl/fdf_bcd.sv =====
// Binary to BCD converter, one shift-and-add-3 step per cycle while conv is asserted, with a digit pop port.
// Depends on fdf_pkg.
module fdf_bcd import fdf_pkg::*; #(
	parameter int NDIG = MAX_INT_DIGITS_DEF
) (
	input  logic             clk,
	input  bcd_ctrl_t        ctrl,
	input  logic [MAG_W-1:0] value,
	output logic [3:0]       digit
);

	localparam int BW = 4 * NDIG;

	logic [MAG_W-1:0] bin_q;
	logic [BW-1:0]    bcd_q;
	logic [BW-1:0]    adj;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (ctrl.conv) begin
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
			bcd_q <= {adj[BW-2:0], bin_q[MAG_W-1]};
		end else if (ctrl.pop) begin
			bcd_q <= {4'd0, bcd_q[BW-1:4]};
		end
	end

	assign digit = bcd_q[3:0];

endmodule

// ===== rtl/fdf_charbuf.sv =====
// Character buffer: one write port, one read port with registered read data.
// Depends on fdf_pkg.
module fdf_charbuf import fdf_pkg::*; #(
	parameter int DEPTH = MAX_INT_DIGITS_DEF + 1 + MAX_PREC_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CHAR_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CHAR_W-1:0] rd_data
);

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/fixed_decimal_formatter_unit.sv =====
// Fixed decimal formatter: one word in, a string of characters out, one item at a time.
// Steps: binary to BCD conversion, the integer digit writes, the point and fraction digits,
// a rounding step, a buffer read and a write back of each digit the rounding carry visits,
// then a buffer read, a load and an output wait per character, held while char_stall is high.
// Reset clears the sequencer to idle; no output word is valid after reset.
module fixed_decimal_formatter_unit import fdf_pkg::*; #(
	parameter int MAX_PREC       = MAX_PREC_DEF,
	parameter int MAX_INT_DIGITS = MAX_INT_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [MAG_W-1:0]  int_magnitude,
	input  logic [NDIG_W-1:0] int_digits,
	input  logic [FRAC_W-1:0] fraction_bits,
	input  logic [PREC_W-1:0] precision,
	output logic              char_valid,
	input  logic              char_stall,
	output logic [CHAR_W-1:0] char_code,
	output logic              last,
	output logic              carry_out
);

	localparam int DEPTH = MAX_INT_DIGITS + 1 + MAX_PREC;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = FRAC_W + 4;

	typedef enum logic [3:0] {
		S_IDLE, S_CONV, S_INTW, S_POINT, S_FRAC, S_RND,
		S_CRD, S_CWR, S_ERD, S_ELD, S_EWAIT
	} state_t;

	state_t            state_q;
	bcd_ctrl_t         bcd_ctrl;
	logic [3:0]        bcd_digit;
	logic [5:0]        bit_cnt_q;
	logic [NDIG_W-1:0] nd_q;
	logic [PREC_W-1:0] prec_q;
	logic [PREC_W-1:0] cnt_q;
	logic [FRAC_W-1:0] fr_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     last_idx_q;
	logic              carry_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              cout_q;

	logic [NDIG_W-1:0] nd_c;
	logic [PREC_W-1:0] prec_c;
	logic [LEN_W-1:0]  len_c;
	logic [PW-1:0]     prod;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CHAR_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CHAR_W-1:0] mem_rdata;

	always_comb begin
		if (int_digits == '0) begin
			nd_c = NDIG_W'(1);
		end else if (int_digits > NDIG_W'(MAX_INT_DIGITS)) begin
			nd_c = NDIG_W'(MAX_INT_DIGITS);
		end else begin
			nd_c = int_digits;
		end
		if (precision > PREC_W'(MAX_PREC)) begin
			prec_c = PREC_W'(MAX_PREC);
		end else begin
			prec_c = precision;
		end
		len_c = LEN_W'(nd_c) + ((prec_c != '0) ? (LEN_W'(prec_c) + LEN_W'(1)) : '0);
	end

	assign prod = {4'd0, fr_q} * PW'(BASE);

	fdf_bcd #(
		.NDIG (MAX_INT_DIGITS)
	) u_bcd (
		.clk   (clk),
		.ctrl  (bcd_ctrl),
		.value (int_magnitude),
		.digit (bcd_digit)
	);

	fdf_charbuf #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	always_comb begin
		bcd_ctrl  = '0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = CH_ZERO;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				bcd_ctrl.load = item_valid;
			end
			S_CONV: begin
				bcd_ctrl.conv = 1'b1;
			end
			S_INTW: begin
				bcd_ctrl.pop = 1'b1;
				mem_we       = 1'b1;
				mem_wdata    = CH_ZERO + CHAR_W'(bcd_digit);
			end
			S_POINT: begin
				mem_we    = 1'b1;
				mem_wdata = CH_POINT;
			end
			S_FRAC: begin
				mem_we    = 1'b1;
				mem_wdata = CH_ZERO + CHAR_W'(prod[PW-1:FRAC_W]);
			end
			S_CRD, S_ERD: begin
				mem_re = 1'b1;
			end
			S_CWR: begin
				if (mem_rdata != CH_POINT) begin
					mem_we = 1'b1;
					if (mem_rdata >= CH_NINE) begin
						mem_wdata = CH_ZERO;
					end else begin
						mem_wdata = mem_rdata + CHAR_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bit_cnt_q  <= '0;
			nd_q       <= '0;
			prec_q     <= '0;
			cnt_q      <= '0;
			fr_q       <= '0;
			ptr_q      <= '0;
			last_idx_q <= '0;
			carry_q    <= 1'b0;
			valid_q    <= 1'b0;
			char_q     <= '0;
			last_q     <= 1'b0;
			cout_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						nd_q       <= nd_c;
						prec_q     <= prec_c;
						fr_q       <= fraction_bits;
						last_idx_q <= AW'(len_c - LEN_W'(1));
						bit_cnt_q  <= '0;
						carry_q    <= 1'b0;
						state_q    <= S_CONV;
					end
				end
				S_CONV: begin
					bit_cnt_q <= bit_cnt_q + 6'd1;
					if (bit_cnt_q == 6'(MAG_W - 1)) begin
						ptr_q   <= AW'(nd_q - NDIG_W'(1));
						state_q <= S_INTW;
					end
				end
				S_INTW: begin
					if (ptr_q == '0) begin
						ptr_q <= AW'(nd_q);
						if (prec_q != '0) begin
							state_q <= S_POINT;
						end else begin
							state_q <= S_RND;
						end
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				S_POINT: begin
					ptr_q   <= ptr_q + AW'(1);
					cnt_q   <= prec_q;
					state_q <= S_FRAC;
				end
				S_FRAC: begin
					fr_q  <= prod[FRAC_W-1:0];
					ptr_q <= ptr_q + AW'(1);
					cnt_q <= cnt_q - PREC_W'(1);
					if (cnt_q == PREC_W'(1)) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					if (prod[PW-1:FRAC_W] >= ROUND_DIGIT) begin
						carry_q <= 1'b1;
						ptr_q   <= last_idx_q;
						state_q <= S_CRD;
					end else begin
						ptr_q   <= '0;
						state_q <= S_ERD;
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					if (mem_rdata != CH_POINT && mem_rdata < CH_NINE) begin
						carry_q <= 1'b0;
						ptr_q   <= '0;
						state_q <= S_ERD;
					end else if (ptr_q == '0) begin
						state_q <= S_ERD;
					end else begin
						ptr_q   <= ptr_q - AW'(1);
						state_q <= S_CRD;
					end
				end
				S_ERD: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					char_q  <= mem_rdata;
					last_q  <= (ptr_q == last_idx_q);
					cout_q  <= carry_q && (ptr_q == last_idx_q);
					valid_q <= 1'b1;
					state_q <= S_EWAIT;
				end
				S_EWAIT: begin
					if (!char_stall) begin
						valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_q + AW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_stall = (state_q != S_IDLE);
	assign char_valid = valid_q;
	assign char_code  = char_q;
	assign last       = last_q;
	assign carry_out  = cout_q;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for fixed_decimal_formatter_unit: drives numeric words, predicts each character string.
// A scoreboard class predicts and checks every output word.
// Depends on fdf_pkg and the RTL of the formatter only.
module tb_top import fdf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
		logic              carry;
	} fmt_char_t;

	class decimal_string_checker;
		fmt_char_t expected_chars[$];
		int        mismatches = 0;

		function void note_word(logic [MAG_W-1:0] mag, logic [NDIG_W-1:0] nd_in,
			logic [FRAC_W-1:0] fr_in, logic [PREC_W-1:0] prec_in);
			logic [CHAR_W-1:0] text [0:MAX_INT_DIGITS_DEF+MAX_PREC_DEF];
			logic [63:0]       m;
			logic [FRAC_W-1:0] fr;
			logic [FRAC_W+3:0] prod;
			int                nd, prec, len, i, pos;
			bit                carry;
			fmt_char_t         c;
			nd = int'(nd_in);
			prec = int'(prec_in);
			if (nd < 1) nd = 1;
			if (nd > MAX_INT_DIGITS_DEF) nd = MAX_INT_DIGITS_DEF;
			if (prec > MAX_PREC_DEF) prec = MAX_PREC_DEF;
			m = {1'b0, mag};
			fr = fr_in;
			for (i = nd - 1; i >= 0; i--) begin
				text[i] = CH_ZERO + CHAR_W'(m % 64'(BASE));
				m = m / 64'(BASE);
			end
			len = nd;
			if (prec > 0) begin
				text[len] = CH_POINT;
				len++;
				for (i = 0; i < prec; i++) begin
					prod = {4'b0, fr} * 68'(BASE);
					text[len] = CH_ZERO + {4'b0, prod[FRAC_W+3:FRAC_W]};
					fr = prod[FRAC_W-1:0];
					len++;
				end
			end
			prod = {4'b0, fr} * 68'(BASE);
			carry = 1'b0;
			if (prod[FRAC_W+3:FRAC_W] >= ROUND_DIGIT) begin
				carry = 1'b1;
				pos = len - 1;
				while (pos >= 0 && carry) begin
					if (text[pos] != CH_POINT) begin
						if (text[pos] >= CH_NINE) begin
							text[pos] = CH_ZERO;
						end else begin
							text[pos] = text[pos] + CHAR_W'(1);
							carry = 1'b0;
						end
					end
					pos--;
				end
			end
			for (i = 0; i < len; i++) begin
				c.code = text[i];
				c.last = (i == len - 1);
				c.carry = (i == len - 1) && carry;
				expected_chars.push_back(c);
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] code, logic last, logic carry);
			fmt_char_t e;
			if (expected_chars.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected character word %0d last %b carry %b",
						$realtime, code, last, carry);
				mismatches++;
				return;
			end
			e = expected_chars.pop_front();
			if (code !== e.code || last !== e.last || carry !== e.carry) begin
				if (mismatches < 10)
					$display("%0t: character mismatch: expected %0d/%b/%b, got %0d/%b/%b",
						$realtime, e.code, e.last, e.carry, code, last, carry);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic [MAG_W-1:0]  int_magnitude;
	logic [NDIG_W-1:0] int_digits;
	logic [FRAC_W-1:0] fraction_bits;
	logic [PREC_W-1:0] precision;
	logic              char_valid;
	logic              char_stall = 1'b0;
	logic [CHAR_W-1:0] char_code;
	logic              last;
	logic              carry_out;

	decimal_string_checker strings = new();
	int idle_pct  = 0;
	int stall_pct = 0;

	fixed_decimal_formatter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.int_magnitude(int_magnitude), .int_digits(int_digits),
		.fraction_bits(fraction_bits), .precision(precision),
		.char_valid(char_valid), .char_stall(char_stall),
		.char_code(char_code), .last(last), .carry_out(carry_out)
	);

	always #6 clk = ~clk;

	initial begin
		#15_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk) begin
		char_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall)
			strings.check_char(char_code, last, carry_out);
	end

	task automatic send_word(logic [MAG_W-1:0] mag, logic [NDIG_W-1:0] nd,
		logic [FRAC_W-1:0] fr, logic [PREC_W-1:0] prec);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 0;
			@(negedge clk);
		end
		item_valid <= 1;
		int_magnitude <= mag;
		int_digits <= nd;
		fraction_bits <= fr;
		precision <= prec;
		do @(posedge clk); while (item_stall);
		strings.note_word(mag, nd, fr, prec);
		@(negedge clk);
	endtask

	task automatic send_random_word();
		logic [MAG_W-1:0]  mag;
		logic [NDIG_W-1:0] nd;
		logic [FRAC_W-1:0] fr;
		logic [PREC_W-1:0] prec;
		int                sel;
		nd = NDIG_W'(($urandom_range(9) < 8) ? $urandom_range(1, 19) : $urandom_range(0, 31));
		sel = $urandom_range(9);
		if (sel < 4) begin
			mag = MAG_W'({$urandom, $urandom});
		end else if (sel < 7) begin
			mag = MAG_W'($urandom_range(999));
		end else begin
			mag = '0;
			repeat (nd) mag = mag * MAG_W'(10) + MAG_W'(9);
		end
		sel = $urandom_range(9);
		if (sel < 7)
			prec = PREC_W'($urandom_range(0, 8));
		else if (sel < 9)
			prec = PREC_W'($urandom_range(9, 44));
		else
			prec = PREC_W'($urandom_range(0, 63));
		sel = $urandom_range(9);
		if (sel < 6)
			fr = {$urandom, $urandom};
		else if (sel < 8)
			fr = ~64'($urandom_range(0, 1 << 20));
		else
			fr = 64'h8000_0000_0000_0000 >> $urandom_range(0, 8);
		send_word(mag, nd, fr, prec);
	endtask

	initial begin
		int phase_idle  [4] = '{0, 50, 0, 25};
		int phase_stall [4] = '{0, 0, 50, 25};
		int p;
		arst_n = 0;
		item_valid = 0;
		int_magnitude = 0;
		int_digits = 0;
		fraction_bits = 0;
		precision = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_word(63'd0, 5'd1, 64'd0, 6'd0);
		send_word(63'h7FFF_FFFF_FFFF_FFFF, 5'd19, 64'hFFFF_FFFF_FFFF_FFFF, 6'd44);
		send_word(63'h7FFF_FFFF_FFFF_FFFF, 5'd31, 64'd0, 6'd63);
		send_word(63'd7, 5'd0, 64'h4000_0000_0000_0000, 6'd2);
		send_word(63'd12345, 5'd5, 64'h8000_0000_0000_0000, 6'd0);
		send_word(63'd12345, 5'd5, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
		send_word(63'd99, 5'd2, 64'hFFFF_FFFF_FFFF_FFFF, 6'd3);
		send_word(63'd9, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
		send_word(63'd19, 5'd2, 64'hF800_0000_0000_0000, 6'd1);
		send_word(63'd4567, 5'd2, 64'h2000_0000_0000_0000, 6'd4);
		send_word(63'd0, 5'd19, 64'h0000_0000_0000_0001, 6'd44);
		send_word(63'h5555_5555_5555_5555, 5'd12, 64'hAAAA_AAAA_AAAA_AAAA, 6'd45);
		send_word(63'h2AAA_AAAA_AAAA_AAAA, 5'd20, 64'h5555_5555_5555_5555, 6'd1);
		send_word(63'd999999999999999999, 5'd18, 64'hFFFF_FFFF_FFFF_0000, 6'd7);
		send_word(63'd0, 5'd3, 64'h1999_9999_9999_999A, 6'd1);
		send_word(63'd1, 5'd1, 64'hE666_6666_6666_6666, 6'd1);
		send_word(63'd8, 5'd1, 64'd0, 6'd32);
		send_word(63'd500, 5'd3, 64'h0CCC_CCCC_CCCC_CCCD, 6'd2);

		for (p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			repeat (48) send_random_word();
			item_valid <= 0;
			while (strings.expected_chars.size() != 0) @(posedge clk);
			@(negedge clk);
		end

		repeat (600) @(posedge clk);
		if (strings.mismatches == 0 && strings.expected_chars.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
